// File: rtl/ccp_pkg.sv
// Package for the calendar clock: item kinds, field widths, result record and calendar helpers.
`default_nettype none

package ccp_pkg;

  // Ticks that make up one second.
  localparam int unsigned TICKS_PER_SECOND = 10;
  localparam int unsigned PRESC_W =
    (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [PRESC_W-1:0] PRESC_RELOAD = PRESC_W'(TICKS_PER_SECOND - 1);

  localparam int unsigned KIND_W = 2;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 7;

  localparam logic [SEC_W:0]    SEC_LIMIT  = 7'd60;
  localparam logic [MIN_W:0]    MIN_LIMIT  = 7'd60;
  localparam logic [HOUR_W:0]   HOUR_LIMIT = 6'd24;
  localparam logic [MON_W:0]    MON_LAST   = 5'd12;
  localparam logic [YEAR_W-1:0] YEAR_LAST  = 7'd99;
  // Year offset whose full year (2100) is a century but not a leap year.
  localparam logic [YEAR_W-1:0] YEAR_2100  = 7'd100;

  localparam logic [DAY_W-1:0] DAYS_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] DAYS_FEB_L = 5'd29;

  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [MON_W-1:0] MON_FIRST = 4'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SEC_W-1:0]  cur_second;
    logic [MIN_W-1:0]  cur_minute;
    logic [HOUR_W-1:0] cur_hour;
    logic [DAY_W-1:0]  cur_day;
    logic [MON_W-1:0]  cur_month;
    logic [YEAR_W-1:0] cur_year;
    logic              is_synced;
    logic              second_pulse;
  } ccp_res_t;

  // 2000 is divisible by 400, so within 2000..2127 the full year is a leap
  // year when the offset is a multiple of four, except for 2100.
  function automatic logic leap_year(input logic [YEAR_W-1:0] yy);
    return (yy[1:0] == 2'b00) && (yy != YEAR_2100);
  endfunction

  // Days in a month; month codes outside 1..12 count as long months.
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic [YEAR_W-1:0] yy);
    logic [DAY_W-1:0] d;
    d = DAYS_LONG;
    if (m == MON_FEB) begin
      d = leap_year(yy) ? DAYS_FEB_L : DAYS_FEB;
    end else if ((m == MON_APR) || (m == MON_JUN) || (m == MON_SEP) || (m == MON_NOV)) begin
      d = DAYS_SHORT;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ccp_if.sv
// Channel interfaces of the calendar clock: input item channel and result channel.
`default_nettype none

interface ccp_in_if;
  logic                       valid;
  logic                       ready;
  logic [ccp_pkg::KIND_W-1:0] kind;
  logic [ccp_pkg::SEC_W-1:0]  load_second;
  logic [ccp_pkg::MIN_W-1:0]  load_minute;
  logic [ccp_pkg::HOUR_W-1:0] load_hour;
  logic [ccp_pkg::DAY_W-1:0]  load_day;
  logic [ccp_pkg::MON_W-1:0]  load_month;
  logic [ccp_pkg::YEAR_W-1:0] load_year;

  modport source (
    output valid, kind, load_second, load_minute, load_hour, load_day, load_month,
           load_year,
    input  ready
  );
  modport sink (
    input  valid, kind, load_second, load_minute, load_hour, load_day, load_month,
           load_year,
    output ready
  );
endinterface

interface ccp_out_if;
  logic                       valid;
  logic                       ready;
  logic [ccp_pkg::SEC_W-1:0]  cur_second;
  logic [ccp_pkg::MIN_W-1:0]  cur_minute;
  logic [ccp_pkg::HOUR_W-1:0] cur_hour;
  logic [ccp_pkg::DAY_W-1:0]  cur_day;
  logic [ccp_pkg::MON_W-1:0]  cur_month;
  logic [ccp_pkg::YEAR_W-1:0] cur_year;
  logic                       is_synced;
  logic                       second_pulse;

  modport source (
    output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year,
           is_synced, second_pulse,
    input  ready
  );
  modport sink (
    input  valid, cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year,
           is_synced, second_pulse,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/calendar_clock_with_tick_prescaler_unit.sv
// Top level of the calendar clock: tick prescaler, date/time cascade and result stage.
//
//   Channel  Direction  Carries
//   in_ch    sink       kind (tick, load, clear) and the date/time fields to load
//   out_ch   source     date/time after the beat, synced mark, second pulse
//
// Every accepted input beat updates the clock state in the same cycle and yields
// exactly one result beat, which goes through the result register to out_ch.
// A new input beat can be taken every cycle while the skid register is empty; the
// prescaler and carry cascade between the input and the result register are combinational.
// rst_n is synchronous and active low; it restores the power-up time (day 1, month 1,
// year 0), clears the synced mark and reloads the prescaler.
// A two-entry output stage (result register plus skid register) keeps in_ch.ready
// high while one result waits; in_ch.ready drops only when both entries are full.
`default_nettype none

module calendar_clock_with_tick_prescaler_unit (
  input wire logic clk,
  input wire logic rst_n,
  ccp_in_if.sink   in_ch,
  ccp_out_if.source out_ch
);
  import ccp_pkg::*;

  // Clock state.
  logic [PRESC_W-1:0] presc_r, presc_nxt;
  logic               synced_r, synced_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic [MIN_W-1:0]   min_r, min_nxt;
  logic [HOUR_W-1:0]  hour_r, hour_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MON_W-1:0]   mon_r, mon_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;

  // Output stage.
  ccp_res_t main_r, main_nxt;
  ccp_res_t skid_r, skid_nxt;
  logic     main_vld_r, main_vld_nxt;
  logic     skid_vld_r, skid_vld_nxt;

  logic     in_acc;
  logic     pulse;
  ccp_res_t res;

  // Cascade intermediates, one bit wider than each counter to catch the wrap.
  logic [SEC_W:0]  sec_inc;
  logic [MIN_W:0]  min_inc;
  logic [HOUR_W:0] hour_inc;
  logic [DAY_W:0]  day_inc;
  logic [MON_W:0]  mon_inc;
  logic [DAY_W-1:0] days_in_mon;

  assign in_ch.ready = !skid_vld_r;
  assign in_acc      = in_ch.valid && !skid_vld_r;

  // Next clock state for the beat on in_ch. The carries ripple through one chain of
  // narrow compares, each counter only moving when all lower ones wrapped.
  always_comb begin
    presc_nxt  = presc_r;
    synced_nxt = synced_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    day_nxt    = day_r;
    mon_nxt    = mon_r;
    year_nxt   = year_r;
    pulse      = 1'b0;

    sec_inc     = {1'b0, sec_r} + 1'b1;
    min_inc     = {1'b0, min_r} + 1'b1;
    hour_inc    = {1'b0, hour_r} + 1'b1;
    day_inc     = {1'b0, day_r} + 1'b1;
    mon_inc     = {1'b0, mon_r} + 1'b1;
    days_in_mon = month_days(mon_r, year_r);

    unique case (in_ch.kind)
      KIND_TICK: begin
        if (presc_r == '0) begin
          presc_nxt = PRESC_RELOAD;
          pulse     = 1'b1;
          if (synced_r) begin
            if (sec_inc < SEC_LIMIT) begin
              sec_nxt = sec_inc[SEC_W-1:0];
            end else begin
              sec_nxt = '0;
              if (min_inc < MIN_LIMIT) begin
                min_nxt = min_inc[MIN_W-1:0];
              end else begin
                min_nxt = '0;
                if (hour_inc < HOUR_LIMIT) begin
                  hour_nxt = hour_inc[HOUR_W-1:0];
                end else begin
                  hour_nxt = '0;
                  if (day_inc <= {1'b0, days_in_mon}) begin
                    day_nxt = day_inc[DAY_W-1:0];
                  end else begin
                    day_nxt = DAY_FIRST;
                    if (mon_inc <= MON_LAST) begin
                      mon_nxt = mon_inc[MON_W-1:0];
                    end else begin
                      mon_nxt  = MON_FIRST;
                      year_nxt = (year_r >= YEAR_LAST) ? '0 : year_r + 1'b1;
                    end
                  end
                end
              end
            end
          end
        end else begin
          presc_nxt = presc_r - 1'b1;
        end
      end
      KIND_LOAD: begin
        sec_nxt    = in_ch.load_second;
        min_nxt    = in_ch.load_minute;
        hour_nxt   = in_ch.load_hour;
        day_nxt    = in_ch.load_day;
        mon_nxt    = in_ch.load_month;
        year_nxt   = in_ch.load_year;
        synced_nxt = 1'b1;
      end
      KIND_CLEAR: begin
        synced_nxt = 1'b0;
      end
      default: begin
        // The unused kind code leaves everything as it is.
      end
    endcase

    res.cur_second   = sec_nxt;
    res.cur_minute   = min_nxt;
    res.cur_hour     = hour_nxt;
    res.cur_day      = day_nxt;
    res.cur_month    = mon_nxt;
    res.cur_year     = year_nxt;
    res.is_synced    = synced_nxt;
    res.second_pulse = pulse;
  end

  // Output stage. The skid entry only fills when the result register is held, and
  // it always drains into the result register before a new beat is taken.
  always_comb begin
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (!main_vld_r || out_ch.ready) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        main_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else if (in_acc) begin
        main_nxt     = res;
        main_vld_nxt = 1'b1;
      end else begin
        main_vld_nxt = 1'b0;
      end
    end else if (in_acc) begin
      skid_nxt     = res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r    <= PRESC_RELOAD;
      synced_r   <= 1'b0;
      sec_r      <= '0;
      min_r      <= '0;
      hour_r     <= '0;
      day_r      <= DAY_FIRST;
      mon_r      <= MON_FIRST;
      year_r     <= '0;
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        presc_r  <= presc_nxt;
        synced_r <= synced_nxt;
        sec_r    <= sec_nxt;
        min_r    <= min_nxt;
        hour_r   <= hour_nxt;
        day_r    <= day_nxt;
        mon_r    <= mon_nxt;
        year_r   <= year_nxt;
      end
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid        = main_vld_r;
  assign out_ch.cur_second   = main_r.cur_second;
  assign out_ch.cur_minute   = main_r.cur_minute;
  assign out_ch.cur_hour     = main_r.cur_hour;
  assign out_ch.cur_day      = main_r.cur_day;
  assign out_ch.cur_month    = main_r.cur_month;
  assign out_ch.cur_year     = main_r.cur_year;
  assign out_ch.is_synced    = main_r.is_synced;
  assign out_ch.second_pulse = main_r.second_pulse;

endmodule

`default_nettype wire

// File: rtl/ccp_checker.sv
// Port-level checker for the calendar clock and its bind to the top level.
`default_nettype none

module ccp_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [ccp_pkg::SEC_W-1:0]  cur_second,
  input wire logic [ccp_pkg::DAY_W-1:0]  cur_day,
  input wire logic                       is_synced,
  input wire logic                       second_pulse
);
  import ccp_pkg::*;

  // Beats taken in but not yet delivered.
  logic [1:0] pend_r, pend_nxt;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_beat && !out_beat) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cur_second) && $stable(cur_day)
      && $stable(is_synced) && $stable(second_pulse))
    else $error("stalled result beat changed or vanished");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid == (pend_r != 2'd0)) && (pend_r != 2'd3))
    else $error("result beats do not match accepted input beats");

  a_backpressure_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && (pend_r == 2'd2))
    else $error("input held off while the output stage has room");

endmodule

bind calendar_clock_with_tick_prescaler_unit ccp_checker u_ccp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .cur_second   (out_ch.cur_second),
  .cur_day      (out_ch.cur_day),
  .is_synced    (out_ch.is_synced),
  .second_pulse (out_ch.second_pulse)
);

`default_nettype wire

// File: sim/ccp_checker.sv
// Scoreboard for the calendar clock: watches both channels, predicts each result beat and compares it.
`default_nettype none

module ccp_scoreboard (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ccp_in_if          in_ch,
  ccp_out_if         out_ch,
  output int unsigned mismatches,
  output int unsigned results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import ccp_pkg::*;

  localparam int unsigned SECS_PER_MIN    = 60;
  localparam int unsigned MINS_PER_HOUR   = 60;
  localparam int unsigned HOURS_PER_DAY   = 24;
  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned LAST_YEAR       = 99;
  localparam int unsigned BASE_YEAR       = 2000;

  // Shadow copy of the clock state.
  int unsigned       presc_count;
  logic              synced_now;
  logic [SEC_W-1:0]  sec_now;
  logic [MIN_W-1:0]  min_now;
  logic [HOUR_W-1:0] hour_now;
  logic [DAY_W-1:0]  day_now;
  logic [MON_W-1:0]  mon_now;
  logic [YEAR_W-1:0] year_now;

  ccp_res_t    owed_q[$];
  int unsigned results_seen;

  function automatic bit is_leap(input logic [YEAR_W-1:0] yy);
    int unsigned full;
    full = BASE_YEAR + yy;
    return (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
  endfunction

  function automatic int unsigned days_in(input logic [MON_W-1:0] m,
                                          input logic [YEAR_W-1:0] yy);
    if (m == MON_FEB) begin
      return is_leap(yy) ? 29 : 28;
    end
    if ((m == MON_APR) || (m == MON_JUN) || (m == MON_SEP) || (m == MON_NOV)) begin
      return 30;
    end
    return 31;
  endfunction

  // Carry one second through the cascade, stopping at the first field that does not wrap.
  task automatic advance_one_second();
    int unsigned nxt;
    nxt = sec_now + 1;
    if (nxt < SECS_PER_MIN) begin
      sec_now = SEC_W'(nxt);
      return;
    end
    sec_now = '0;
    nxt = min_now + 1;
    if (nxt < MINS_PER_HOUR) begin
      min_now = MIN_W'(nxt);
      return;
    end
    min_now = '0;
    nxt = hour_now + 1;
    if (nxt < HOURS_PER_DAY) begin
      hour_now = HOUR_W'(nxt);
      return;
    end
    hour_now = '0;
    nxt = day_now + 1;
    if (nxt <= days_in(mon_now, year_now)) begin
      day_now = DAY_W'(nxt);
      return;
    end
    day_now = DAY_FIRST;
    nxt = mon_now + 1;
    if (nxt <= MONTHS_PER_YEAR) begin
      mon_now = MON_W'(nxt);
      return;
    end
    mon_now = MON_FIRST;
    year_now = (year_now >= LAST_YEAR) ? '0 : year_now + 1'b1;
  endtask

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report($sformatf("result beat %0d, %s = %0d, expected %0d", results_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    ccp_res_t got;
    ccp_res_t want;
    logic     pulse;
    if (!rst_n) begin
      presc_count  = TICKS_PER_SECOND - 1;
      synced_now   = 1'b0;
      sec_now      = '0;
      min_now      = '0;
      hour_now     = '0;
      day_now      = DAY_FIRST;
      mon_now      = MON_FIRST;
      year_now     = '0;
      mismatches   = 0;
      results_seen = 0;
      owed_q.delete();
    end else begin
      // A result beat always passes through the result register after its input beat,
      // so the result is matched before this edge's input is predicted.
      if (out_ch.valid && out_ch.ready) begin
        got.cur_second   = out_ch.cur_second;
        got.cur_minute   = out_ch.cur_minute;
        got.cur_hour     = out_ch.cur_hour;
        got.cur_day      = out_ch.cur_day;
        got.cur_month    = out_ch.cur_month;
        got.cur_year     = out_ch.cur_year;
        got.is_synced    = out_ch.is_synced;
        got.second_pulse = out_ch.second_pulse;
        if (owed_q.size() == 0) begin
          report($sformatf("result beat %0d arrived with no input beat owed", results_seen));
        end else begin
          want = owed_q.pop_front();
          check_field("cur_second", 32'(got.cur_second), 32'(want.cur_second));
          check_field("cur_minute", 32'(got.cur_minute), 32'(want.cur_minute));
          check_field("cur_hour", 32'(got.cur_hour), 32'(want.cur_hour));
          check_field("cur_day", 32'(got.cur_day), 32'(want.cur_day));
          check_field("cur_month", 32'(got.cur_month), 32'(want.cur_month));
          check_field("cur_year", 32'(got.cur_year), 32'(want.cur_year));
          check_field("is_synced", 32'(got.is_synced), 32'(want.is_synced));
          check_field("second_pulse", 32'(got.second_pulse), 32'(want.second_pulse));
        end
        results_seen++;
      end

      if (in_ch.valid && in_ch.ready) begin
        pulse = 1'b0;
        case (in_ch.kind)
          KIND_TICK: begin
            if (presc_count == 0) begin
              presc_count = TICKS_PER_SECOND - 1;
              pulse = 1'b1;
              if (synced_now) begin
                advance_one_second();
              end
            end else begin
              presc_count--;
            end
          end
          KIND_LOAD: begin
            sec_now    = in_ch.load_second;
            min_now    = in_ch.load_minute;
            hour_now   = in_ch.load_hour;
            day_now    = in_ch.load_day;
            mon_now    = in_ch.load_month;
            year_now   = in_ch.load_year;
            synced_now = 1'b1;
          end
          KIND_CLEAR: begin
            synced_now = 1'b0;
          end
          default: begin
          end
        endcase
        want.cur_second   = sec_now;
        want.cur_minute   = min_now;
        want.cur_hour     = hour_now;
        want.cur_day      = day_now;
        want.cur_month    = mon_now;
        want.cur_year     = year_now;
        want.is_synced    = synced_now;
        want.second_pulse = pulse;
        owed_q.push_back(want);
      end
    end
    results_owed = owed_q.size();
  end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Testbench top for the calendar clock: clock, reset, input and result drivers, and the verdict.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccp_pkg::*;

  // The channel allows a fourth kind code that the block must treat as a no-op.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS    = 750;
  localparam int unsigned MAX_GAP         = 11;
  // Long enough for the two-entry output stage to fill and push back on in_ch.
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned BURST_ITEMS     = 24;
  localparam int unsigned DRAIN_CYCLES    = 16;
  // Slowest run is roughly 800 beats with a random gap on each side; the limit leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned QUIET_PERIOD    = 40;

  logic clk;
  logic rst_n;

  ccp_in_if  in_ch();
  ccp_out_if out_ch();

  int unsigned mismatches;
  int unsigned results_owed;

  // Quiet flags switch off the random gaps for a stretch of beats on one side.
  bit          send_quiet;
  bit          recv_quiet;
  // A burst forces back-to-back input beats; the hold-off request stops the result side.
  bit          sender_burst;
  bit          hold_off_request;
  int unsigned items_sent;
  int unsigned cycles;

  calendar_clock_with_tick_prescaler_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ccp_scoreboard scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one input beat after a random gap and hold it until the block takes it.
  // The valid line is only lowered when there is a real gap, so back-to-back beats
  // never see a low and a high scheduled in the same time step.
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [SEC_W-1:0]  sec,
                           input logic [MIN_W-1:0]  min,
                           input logic [HOUR_W-1:0] hour,
                           input logic [DAY_W-1:0]  day,
                           input logic [MON_W-1:0]  mon,
                           input logic [YEAR_W-1:0] year);
    int unsigned gap;
    gap = (send_quiet || sender_burst) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.load_second <= sec;
    in_ch.load_minute <= min;
    in_ch.load_hour   <= hour;
    in_ch.load_day    <= day;
    in_ch.load_month  <= mon;
    in_ch.load_year   <= year;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (items_sent % QUIET_PERIOD == 0) begin
      send_quiet = ($urandom_range(0, 3) == 0);
    end
  endtask

  // Ticks and clears carry random junk in the load fields, which the block must ignore.
  task automatic send_with_junk(input logic [KIND_W-1:0] kind);
    send_item(kind, SEC_W'($urandom()), MIN_W'($urandom()), HOUR_W'($urandom()),
              DAY_W'($urandom()), MON_W'($urandom()), YEAR_W'($urandom()));
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_with_junk(KIND_TICK);
  endtask

  function automatic logic [MON_W-1:0] MONTHS_DEC();
    return MON_LAST[MON_W-1:0];
  endfunction

  // Load near a rollover, each field in its range (the day may pass the month's end),
  // then enough ticks to cross one or more seconds. Heavy weight on 59 s, 59 min, 23 h,
  // month ends, December, year 99 and leap and non-leap February for the deep carries.
  task automatic calendar_walk();
    logic [SEC_W-1:0]  sec;
    logic [MIN_W-1:0]  min;
    logic [HOUR_W-1:0] hour;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  mon;
    logic [YEAR_W-1:0] year;
    int unsigned       n;
    sec  = ($urandom_range(0, 3) == 0) ? SEC_W'($urandom_range(0, 59))
                                       : SEC_W'($urandom_range(55, 59));
    min  = ($urandom_range(0, 1) == 0) ? MIN_W'($urandom_range(0, 59)) : MIN_W'(59);
    hour = ($urandom_range(0, 1) == 0) ? HOUR_W'($urandom_range(0, 23)) : HOUR_W'(23);
    case ($urandom_range(0, 3))
      0:       mon = MON_FEB;
      1:       mon = MONTHS_DEC();
      default: mon = MON_W'($urandom_range(1, 12));
    endcase
    day = ($urandom_range(0, 1) == 0) ? DAY_W'($urandom_range(1, 31))
                                      : DAY_W'($urandom_range(28, 31));
    case ($urandom_range(0, 3))
      0:       year = YEAR_LAST;
      1:       year = YEAR_W'(4 * $urandom_range(0, 24));
      default: year = YEAR_W'($urandom_range(0, 99));
    endcase
    send_item(KIND_LOAD, sec, min, hour, day, mon, year);
    n = $urandom_range(10, 60);
    repeat (n) begin
      // Now and then the clock loses sync mid-walk and must freeze while ticks go on.
      if ($urandom_range(0, 49) == 0) begin
        send_with_junk(KIND_CLEAR);
      end else begin
        send_with_junk(KIND_TICK);
      end
    end
  endtask

  // Loads, often out of range: the block stores them masked and wraps on carry.
  // One in four is the last second of 28 February 2100, a century that is not leap.
  task automatic broken_load();
    if ($urandom_range(0, 3) == 0) begin
      send_item(KIND_LOAD, SEC_W'(59), MIN_W'(59), HOUR_W'(23), DAYS_FEB, MON_FEB, YEAR_2100);
    end else begin
      send_item(KIND_LOAD, SEC_W'($urandom()), MIN_W'($urandom()), HOUR_W'($urandom()),
                DAY_W'($urandom()), MON_W'($urandom()), YEAR_W'($urandom()));
    end
    send_ticks($urandom_range(10, 30));
  endtask

  // Fully random beats, unused kind code included.
  task automatic noise_burst();
    repeat ($urandom_range(5, 20)) begin
      send_with_junk(KIND_W'($urandom_range(0, 3)));
    end
  endtask

  // Result side: random stall before every beat, quiet stretches, and one long
  // hold-off when asked for, counted here so the sender keeps pushing meanwhile.
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          hold_off_done;
    taken         = 0;
    hold_off_done = 1'b0;
    recv_quiet    = 1'b0;
    out_ch.ready  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_request && !hold_off_done) begin
        hold_off_done = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if (taken % QUIET_PERIOD == 0) begin
        recv_quiet = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Stimulus: reset, a directed opening, then the random part, then drain and verdict.
  initial begin
    int unsigned scenario;
    int unsigned target;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_TICK;
    in_ch.load_second = '0;
    in_ch.load_minute = '0;
    in_ch.load_hour   = '0;
    in_ch.load_day    = '0;
    in_ch.load_month  = '0;
    in_ch.load_year   = '0;
    send_quiet        = 1'b0;
    sender_burst      = 1'b0;
    hold_off_request  = 1'b0;
    items_sent        = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. The unused kind with every load bit set must change nothing.
    send_item(KIND_UNUSED, '1, '1, '1, '1, '1, '1);
    // All-zero load: day 0 and month 0 are stored as given, month 0 counts as 31 days.
    send_item(KIND_LOAD, '0, '0, '0, '0, '0, '0);
    send_with_junk(KIND_CLEAR);
    // Ten ticks while unsynced: the tenth still pulses, the time stays frozen.
    send_ticks(TICKS_PER_SECOND);
    // All-ones load, then a completed second: every field is at or past its limit, so
    // seconds, minutes and hours wrap to 0, day and month to 1 and year 127 to 0.
    send_item(KIND_LOAD, '1, '1, '1, '1, '1, '1);
    send_ticks(TICKS_PER_SECOND);

    // Random part.
    target   = items_sent + RANDOM_ITEMS;
    scenario = 0;
    while (items_sent < target) begin
      scenario++;
      if (scenario == 8) begin
        // Stop the result side for a long stretch while beats keep coming back to back,
        // so the output stage fills and in_ch.ready has to drop.
        hold_off_request = 1'b1;
        sender_burst     = 1'b1;
        send_ticks(BURST_ITEMS);
        sender_burst     = 1'b0;
      end
      if (scenario % 15 == 0) begin
        // Let the block drain completely before going on.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (results_owed == 0);
      end
      case ($urandom_range(0, 9))
        7:       broken_load();
        8, 9:    noise_burst();
        default: calendar_walk();
      endcase
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (results_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
